[rtl/rlyatt_pkg.sv]
// Shared types and constants for the relay attenuator sequencer.
// Holds the microcode word layout, program step addresses and relay masks.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rlyatt_pkg;

  // Attenuator stages that have a relay (code bits at or above do not)
  localparam int STAGES = 7;
  localparam int VOL_W  = 7;
  localparam int WORD_W = 16;

  localparam logic [VOL_W-1:0]  STAGE_MASK  = VOL_W'((1 << STAGES) - 1);
  localparam logic [WORD_W-1:0] RESET_RELAY = 16'h4100;
  localparam logic [WORD_W-1:0] POWER_MASK  = 16'h4000;
  localparam logic [WORD_W-1:0] INPUT_CLEAR = 16'hf0ff;
  localparam logic [3:0]        INPUT_WRAP  = 4'h1;
  localparam logic [2:0]        MUTE_BIT    = 3'd7;

  // Command codes
  localparam logic [1:0] CMD_SET_VOL  = 2'd0;
  localparam logic [1:0] CMD_NEXT_IN  = 2'd1;
  localparam logic [1:0] CMD_POWER_ON = 2'd2;
  localparam logic [1:0] CMD_POWER_OFF = 2'd3;

  // Input index codes
  localparam logic [1:0] IDX_CD      = 2'd0;
  localparam logic [1:0] IDX_PHONO   = 2'd1;
  localparam logic [1:0] IDX_NETWORK = 2'd2;
  localparam logic [1:0] IDX_AUX     = 2'd3;

  // Microcode program layout
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_FETCH   = 5'd0;
  localparam logic [STEP_W-1:0] STEP_MUTE    = 5'd1;
  localparam logic [STEP_W-1:0] STEP_CLR6    = 5'd2;
  localparam logic [STEP_W-1:0] STEP_CLR5    = 5'd3;
  localparam logic [STEP_W-1:0] STEP_CLR4    = 5'd4;
  localparam logic [STEP_W-1:0] STEP_CLR3    = 5'd5;
  localparam logic [STEP_W-1:0] STEP_CLR2    = 5'd6;
  localparam logic [STEP_W-1:0] STEP_CLR1    = 5'd7;
  localparam logic [STEP_W-1:0] STEP_CLR0    = 5'd8;
  localparam logic [STEP_W-1:0] STEP_SET0    = 5'd9;
  localparam logic [STEP_W-1:0] STEP_SET1    = 5'd10;
  localparam logic [STEP_W-1:0] STEP_SET2    = 5'd11;
  localparam logic [STEP_W-1:0] STEP_SET3    = 5'd12;
  localparam logic [STEP_W-1:0] STEP_SET4    = 5'd13;
  localparam logic [STEP_W-1:0] STEP_SET5    = 5'd14;
  localparam logic [STEP_W-1:0] STEP_SET6    = 5'd15;
  localparam logic [STEP_W-1:0] STEP_NEXT_IN = 5'd16;
  localparam logic [STEP_W-1:0] STEP_PWR_ON  = 5'd17;
  localparam logic [STEP_W-1:0] STEP_PWR_OFF = 5'd18;

  typedef enum logic [2:0] {
    OP_FETCH,
    OP_MUTE,
    OP_CLR,
    OP_SET,
    OP_NEXT_IN,
    OP_PWR_ON,
    OP_PWR_OFF
  } op_t;

  typedef enum logic [1:0] {
    JMP_SEQ,   // next step, or home when no relay change is left
    JMP_CMD,   // dispatch on the command of the accepted item
    JMP_HOME   // back to fetch
  } jmp_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] bitsel;
    jmp_t       jmp;
  } ucode_t;

  // Sequencer to datapath
  typedef struct packed {
    op_t              op;
    logic [2:0]       bitsel;
    logic             fire;
    logic             load_vol;
    logic [VOL_W-1:0] new_volume;
  } dp_ctl_t;

  // Datapath to sequencer
  typedef struct packed {
    logic emit;
    logic rest_empty;
    logic out_full;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/rlyatt_ucode_rom.sv]
// Microcode program store for the relay attenuator sequencer.
// One control word per step address. Depends on rlyatt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlyatt_ucode_rom import rlyatt_pkg::*; (
  input  wire logic [STEP_W-1:0] addr,
  output ucode_t                 uword
);

  // Program: fetch, mute, clear stages high to low, set stages low to high,
  // then one word each for the single-word commands
  always_comb begin
    case (addr)
      STEP_FETCH:   uword = '{op: OP_FETCH,   bitsel: 3'd0, jmp: JMP_CMD};
      STEP_MUTE:    uword = '{op: OP_MUTE,    bitsel: MUTE_BIT, jmp: JMP_SEQ};
      STEP_CLR6:    uword = '{op: OP_CLR,     bitsel: 3'd6, jmp: JMP_SEQ};
      STEP_CLR5:    uword = '{op: OP_CLR,     bitsel: 3'd5, jmp: JMP_SEQ};
      STEP_CLR4:    uword = '{op: OP_CLR,     bitsel: 3'd4, jmp: JMP_SEQ};
      STEP_CLR3:    uword = '{op: OP_CLR,     bitsel: 3'd3, jmp: JMP_SEQ};
      STEP_CLR2:    uword = '{op: OP_CLR,     bitsel: 3'd2, jmp: JMP_SEQ};
      STEP_CLR1:    uword = '{op: OP_CLR,     bitsel: 3'd1, jmp: JMP_SEQ};
      STEP_CLR0:    uword = '{op: OP_CLR,     bitsel: 3'd0, jmp: JMP_SEQ};
      STEP_SET0:    uword = '{op: OP_SET,     bitsel: 3'd0, jmp: JMP_SEQ};
      STEP_SET1:    uword = '{op: OP_SET,     bitsel: 3'd1, jmp: JMP_SEQ};
      STEP_SET2:    uword = '{op: OP_SET,     bitsel: 3'd2, jmp: JMP_SEQ};
      STEP_SET3:    uword = '{op: OP_SET,     bitsel: 3'd3, jmp: JMP_SEQ};
      STEP_SET4:    uword = '{op: OP_SET,     bitsel: 3'd4, jmp: JMP_SEQ};
      STEP_SET5:    uword = '{op: OP_SET,     bitsel: 3'd5, jmp: JMP_SEQ};
      STEP_SET6:    uword = '{op: OP_SET,     bitsel: 3'd6, jmp: JMP_HOME};
      STEP_NEXT_IN: uword = '{op: OP_NEXT_IN, bitsel: 3'd0, jmp: JMP_HOME};
      STEP_PWR_ON:  uword = '{op: OP_PWR_ON,  bitsel: 3'd0, jmp: JMP_HOME};
      STEP_PWR_OFF: uword = '{op: OP_PWR_OFF, bitsel: 3'd0, jmp: JMP_HOME};
      default:      uword = '{op: OP_FETCH,   bitsel: 3'd0, jmp: JMP_HOME};
    endcase
  end

endmodule

`default_nettype wire

[rtl/rlyatt_datapath.sv]
// Datapath of the relay attenuator sequencer: relay word, last volume,
// pending change masks and the output register. Depends on rlyatt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rlyatt_datapath import rlyatt_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  dp_ctl_t                ctl,
  output dp_stat_t               stat,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [WORD_W-1:0]      out_word,
  output logic [1:0]             out_index,
  output logic                   out_last
);

  logic [WORD_W-1:0] relay_r, relay_nxt;
  logic [VOL_W-1:0]  prev_vol_r, prev_vol_nxt;
  logic [VOL_W-1:0]  clr_r, clr_nxt;
  logic [VOL_W-1:0]  set_r, set_nxt;
  logic              mute_pend_r, mute_pend_nxt;
  logic              mute_on_r, mute_on_nxt;
  logic              valid_r, valid_nxt;
  logic [WORD_W-1:0] word_r, word_nxt;
  logic [1:0]        index_r, index_nxt;
  logic              last_r, last_nxt;

  logic [VOL_W-1:0]  stage_bit;
  logic [WORD_W-1:0] relay_bit;
  logic [WORD_W-1:0] relay_new;
  logic [WORD_W-1:0] emit_word;
  logic [4:0]        nib_shift;
  logic [3:0]        nib_new;
  logic              emit;
  logic              rest_empty;

  assign stage_bit = VOL_W'(1) << ctl.bitsel;
  assign relay_bit = WORD_W'(1) << ctl.bitsel;

  // Rotate the one-hot input nibble, wrapping past the top input
  assign nib_shift = {relay_r[11:8], 1'b0};
  assign nib_new   = (nib_shift > 5'd8) ? INPUT_WRAP : nib_shift[3:0];

  // Decode one micro-op: does it emit, what word, anything left after it
  always_comb begin
    emit       = 1'b1;
    rest_empty = 1'b1;
    relay_new  = relay_r;
    emit_word  = relay_r;
    case (ctl.op)
      OP_FETCH: begin
        emit = 1'b0;
      end
      OP_MUTE: begin
        emit       = mute_pend_r;
        rest_empty = (clr_r == '0) && (set_r == '0);
        relay_new  = mute_on_r ? (relay_r | relay_bit) : (relay_r & ~relay_bit);
        emit_word  = relay_new;
      end
      OP_CLR: begin
        emit       = |(clr_r & stage_bit);
        rest_empty = ((clr_r & ~stage_bit) == '0) && (set_r == '0);
        relay_new  = relay_r & ~relay_bit;
        emit_word  = relay_new;
      end
      OP_SET: begin
        emit       = |(set_r & stage_bit);
        rest_empty = (set_r & ~stage_bit) == '0;
        relay_new  = relay_r | relay_bit;
        emit_word  = relay_new;
      end
      OP_NEXT_IN: begin
        relay_new = (relay_r & INPUT_CLEAR) | {4'h0, nib_new, 8'h00};
        emit_word = relay_new;
      end
      OP_PWR_ON: begin
        relay_new = relay_r | POWER_MASK;
        emit_word = relay_new;
      end
      OP_PWR_OFF: begin
        relay_new = relay_r & ~POWER_MASK;
        emit_word = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Update state and the output register
  always_comb begin
    relay_nxt     = relay_r;
    prev_vol_nxt  = prev_vol_r;
    clr_nxt       = clr_r;
    set_nxt       = set_r;
    mute_pend_nxt = mute_pend_r;
    mute_on_nxt   = mute_on_r;
    valid_nxt     = valid_r & ~out_ready;
    word_nxt      = word_r;
    index_nxt     = index_r;
    last_nxt      = last_r;

    // Capture the change masks when a volume item is taken
    if (ctl.load_vol) begin
      clr_nxt       = prev_vol_r & ~ctl.new_volume & STAGE_MASK;
      set_nxt       = ctl.new_volume & ~prev_vol_r & STAGE_MASK;
      mute_pend_nxt = (ctl.new_volume != '0) != (prev_vol_r != '0);
      mute_on_nxt   = ctl.new_volume != '0;
      prev_vol_nxt  = ctl.new_volume;
    end

    // Retire the step: drop its pending bit, emit its word
    if (ctl.fire && emit) begin
      relay_nxt = relay_new;
      valid_nxt = 1'b1;
      word_nxt  = emit_word;
      last_nxt  = rest_empty;
      case (relay_new[11:8])
        4'h1:    index_nxt = IDX_CD;
        4'h2:    index_nxt = IDX_PHONO;
        4'h4:    index_nxt = IDX_NETWORK;
        default: index_nxt = IDX_AUX;
      endcase
      case (ctl.op)
        OP_MUTE: mute_pend_nxt = 1'b0;
        OP_CLR:  clr_nxt       = clr_r & ~stage_bit;
        OP_SET:  set_nxt       = set_r & ~stage_bit;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_r     <= RESET_RELAY;
      prev_vol_r  <= '0;
      clr_r       <= '0;
      set_r       <= '0;
      mute_pend_r <= 1'b0;
      mute_on_r   <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      relay_r     <= relay_nxt;
      prev_vol_r  <= prev_vol_nxt;
      clr_r       <= clr_nxt;
      set_r       <= set_nxt;
      mute_pend_r <= mute_pend_nxt;
      mute_on_r   <= mute_on_nxt;
      valid_r     <= valid_nxt;
    end
    word_r  <= word_nxt;
    index_r <= index_nxt;
    last_r  <= last_nxt;
  end

  assign stat.emit       = emit;
  assign stat.rest_empty = rest_empty;
  assign stat.out_full   = valid_r & ~out_ready;

  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign out_index = index_r;
  assign out_last  = last_r;

endmodule

`default_nettype wire

[rtl/relay_attenuator_sequencer_top.sv]
// Top level of the relay attenuator sequencer: step counter, jump logic and
// stream handshakes. Depends on rlyatt_pkg, rlyatt_ucode_rom, rlyatt_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Turns volume, input select and power commands into a sequence of 16-bit
// relay words for two cascaded shift registers, one relay change per word.
// A volume change drives the mute relay first, then drops attenuator stages
// from the highest down, then adds stages from the lowest up; tlast marks the
// final word of each command, and an unchanged volume gives no word at all.
// The block works on one item at a time: a microcode program steps once per
// cycle, except while an emitting step waits for the output register to be
// free of an untaken word. Next input, power on and power off run a fetch and
// one step; a volume command runs a fetch, the mute step, then one step per
// stage position up to the last stage that changes. After reset the
// relay word is 16'h4100 (power on, first input) and the last volume is 0.
module relay_attenuator_sequencer_top import rlyatt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [6:0] new_volume
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [15:0] relay_word, [17:16] input_index
  output logic             out_tlast   // last_of_run
);

  logic [STEP_W-1:0] step_r, step_nxt;
  ucode_t            uword;
  dp_ctl_t           ctl;
  dp_stat_t          stat;
  logic              in_take;
  logic              advance;
  logic [WORD_W-1:0] out_word;
  logic [1:0]        out_index;

  rlyatt_ucode_rom u_rom (
    .addr  (step_r),
    .uword (uword)
  );

  assign in_tready = (uword.op == OP_FETCH);
  assign in_take   = in_tvalid & in_tready;

  // Fetch waits for an item; an emitting step waits for room at the output
  assign advance = (uword.op == OP_FETCH) ? in_take : ~(stat.emit & stat.out_full);

  assign ctl.op         = uword.op;
  assign ctl.bitsel     = uword.bitsel;
  assign ctl.fire       = advance;
  assign ctl.load_vol   = in_take & (in_tuser == CMD_SET_VOL);
  assign ctl.new_volume = in_tdata[VOL_W-1:0];

  // Next step address
  always_comb begin
    step_nxt = step_r;
    if (advance) begin
      case (uword.jmp)
        JMP_CMD: begin
          case (in_tuser)
            CMD_SET_VOL:   step_nxt = STEP_MUTE;
            CMD_NEXT_IN:   step_nxt = STEP_NEXT_IN;
            CMD_POWER_ON:  step_nxt = STEP_PWR_ON;
            CMD_POWER_OFF: step_nxt = STEP_PWR_OFF;
            default:       step_nxt = STEP_FETCH;
          endcase
        end
        JMP_SEQ: begin
          step_nxt = stat.rest_empty ? STEP_FETCH : step_r + STEP_W'(1);
        end
        JMP_HOME: begin
          step_nxt = STEP_FETCH;
        end
        default: begin
          step_nxt = STEP_FETCH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

  rlyatt_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat      (stat),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_word  (out_word),
    .out_index (out_index),
    .out_last  (out_tlast)
  );

  assign out_tdata = {6'b0, out_index, out_word};

endmodule

`default_nettype wire

[rtl/rlyatt_checker.sv]
// Port-level checks for the relay attenuator sequencer, bound to the top.
// Depends on relay_attenuator_sequencer_top port names only.
`timescale 1ns / 1ps
`default_nettype none

module rlyatt_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [7:0]  in_tdata,
  input wire logic [1:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [23:0] out_tdata,
  input wire logic        out_tlast
);

  // Hold a stalled result item
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result item changed");

  // Hold a waiting input item until it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("waiting input item changed");

  // One item at a time: no new item right after one is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // A run still in progress keeps the input closed
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("input open while a run is unfinished");

  // Unused relay bits stay off and the index matches the cd relay
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[15] == 1'b0) && (out_tdata[13:12] == 2'b00) &&
      (out_tdata[23:18] == 6'b0) &&
      ((out_tdata[11:8] != 4'h1) || (out_tdata[17:16] == 2'd0)))
    else $error("malformed relay word");

endmodule

bind relay_attenuator_sequencer_top rlyatt_checker u_rlyatt_checker (.*);

`default_nettype wire

[tb/relay_word_checker.sv]
// Scoreboard for the relay attenuator sequencer: watches both stream channels,
// predicts the relay words of each accepted command and compares them in order.
// Depends on rlyatt_pkg for widths, command codes and relay masks.
`timescale 1ns / 1ps

module relay_word_checker import rlyatt_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [7:0]  in_tdata,   // [6:0] new_volume
  input  wire logic [1:0]  in_tuser,   // [1:0] command
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [23:0] out_tdata,  // [15:0] relay_word, [17:16] input_index
  input  wire logic        out_tlast,  // last_of_run
  input  wire logic        run_done,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [WORD_W-1:0] relay_word;
    logic [1:0]        input_index;
    logic              last;
  } relay_result_t;

  logic [WORD_W-1:0] model_relays;
  logic [VOL_W-1:0]  model_volume;
  relay_result_t     expected_words[$];
  int                mismatches = 0;
  bit                leftovers_checked = 1'b0;

  // Decode the one-hot input nibble; anything not one-hot reads as aux
  function automatic logic [1:0] input_of(logic [WORD_W-1:0] word);
    case (word[11:8])
      4'h1: return IDX_CD;
      4'h2: return IDX_PHONO;
      4'h4: return IDX_NETWORK;
      default: return IDX_AUX;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Queue one word; the index always follows the stored relays
  task automatic push_word(logic [WORD_W-1:0] word);
    relay_result_t r;
    r.relay_word  = word;
    r.input_index = input_of(model_relays);
    r.last        = 1'b0;
    expected_words.push_back(r);
  endtask

  task automatic flip_relay(int pos, logic on);
    model_relays[pos] = on;
    push_word(model_relays);
  endtask

  // Work out the words one command causes and mark the final one
  task automatic predict_relay_words(logic [1:0] cmd, logic [VOL_W-1:0] vol);
    int                words_before;
    int                i;
    logic [VOL_W-1:0]  prev;
    logic [4:0]        shifted;
    relay_result_t     tail;
    words_before = expected_words.size();
    prev = model_volume;
    case (cmd)
      CMD_SET_VOL: begin
        if (vol != prev) begin
          if (vol != '0 && prev == '0)
            flip_relay(MUTE_BIT, 1'b1);
          else if (vol == '0 && prev != '0)
            flip_relay(MUTE_BIT, 1'b0);
          // Drop stages from the top, then add from the bottom
          for (i = STAGES - 1; i >= 0; i--)
            if (prev[i] && !vol[i])
              flip_relay(i, 1'b0);
          for (i = 0; i < STAGES; i++)
            if (vol[i] && !prev[i])
              flip_relay(i, 1'b1);
          model_volume = vol;
        end
      end
      CMD_NEXT_IN: begin
        shifted = {1'b0, model_relays[11:8]} << 1;
        if (shifted > 5'd8)
          shifted = 5'd1;
        model_relays = (model_relays & INPUT_CLEAR) | {4'h0, shifted[3:0], 8'h00};
        push_word(model_relays);
      end
      CMD_POWER_ON: begin
        model_relays = model_relays | POWER_MASK;
        push_word(model_relays);
      end
      default: begin
        model_relays = model_relays & ~POWER_MASK;
        push_word('0);
      end
    endcase
    if (expected_words.size() > words_before) begin
      tail = expected_words.pop_back();
      tail.last = 1'b1;
      expected_words.push_back(tail);
    end
  endtask

  // Compare taken words first, then predict for a newly taken command
  always @(posedge clk) begin
    relay_result_t want;
    if (!rst_n) begin
      model_relays = RESET_RELAY;
      model_volume = '0;
      expected_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %h with none expected", out_tdata[15:0]));
        end else begin
          want = expected_words.pop_front();
          if (out_tdata[15:0] !== want.relay_word)
            report_mismatch($sformatf("relay_word %h, want %h",
                                      out_tdata[15:0], want.relay_word));
          if (out_tdata[17:16] !== want.input_index)
            report_mismatch($sformatf("input_index %0d, want %0d",
                                      out_tdata[17:16], want.input_index));
          if (out_tlast !== want.last)
            report_mismatch($sformatf("last_of_run %b, want %b on word %h",
                                      out_tlast, want.last, want.relay_word));
        end
      end
      if (in_tvalid && in_tready)
        predict_relay_words(in_tuser, in_tdata[VOL_W-1:0]);
      if (run_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_words.size() != 0)
          report_mismatch($sformatf("%0d expected words never came",
                                    expected_words.size()));
      end
    end
    pending    <= expected_words.size();
    fail_count <= mismatches;
  end

endmodule

[tb/tb_relay_attenuator_sequencer_top.sv]
// Testbench top for the relay attenuator sequencer: drives directed and random
// commands with random idling on both channels and gives the verdict.
// Depends on rlyatt_pkg, relay_attenuator_sequencer_top and relay_word_checker.
`timescale 1ns / 1ps

module tb_relay_attenuator_sequencer_top;
  import rlyatt_pkg::*;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [7:0]       in_tdata   = '0;
  logic [1:0]       in_tuser   = CMD_SET_VOL;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [23:0]      out_tdata;
  logic             out_tlast;
  logic             run_done   = 1'b0;
  int               fail_count;
  int               pending;
  int               send_idle_pct = 6;
  int               recv_idle_pct = 6;
  logic [VOL_W-1:0] last_volume   = '0;

  relay_attenuator_sequencer_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  relay_word_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .run_done   (run_done),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #400000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stall the result side at random
  always @(posedge clk)
    out_tready <= ($urandom_range(99) >= recv_idle_pct);

  // Offer one command, idling first at random, and hold until taken
  task automatic send_item(logic [1:0] cmd, logic [VOL_W-1:0] vol);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {1'b0, vol};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    if (cmd == CMD_SET_VOL)
      last_volume = vol;
  endtask

  // Hold off until every predicted word has been taken
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
  endtask

  initial begin
    int               n;
    int               pick;
    logic [1:0]       cmd;
    logic [VOL_W-1:0] vol;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Volume extremes, unchanged volume, mute edges, stage order
    send_item(CMD_SET_VOL, 7'd0);
    send_item(CMD_SET_VOL, 7'd127);
    send_item(CMD_SET_VOL, 7'd127);
    send_item(CMD_SET_VOL, 7'd0);
    send_item(CMD_SET_VOL, 7'd1);
    send_item(CMD_SET_VOL, 7'd64);
    send_item(CMD_SET_VOL, 7'd63);
    send_item(CMD_SET_VOL, 7'd42);
    send_item(CMD_SET_VOL, 7'd85);
    send_item(CMD_SET_VOL, 7'd0);
    // Walk all inputs and wrap back to the first
    send_item(CMD_NEXT_IN, 7'd127);
    send_item(CMD_NEXT_IN, 7'd0);
    send_item(CMD_NEXT_IN, 7'd85);
    send_item(CMD_NEXT_IN, 7'd42);
    // Power handling, volume and input changes while off
    send_item(CMD_POWER_OFF, 7'd0);
    send_item(CMD_POWER_OFF, 7'd127);
    send_item(CMD_SET_VOL, 7'd85);
    send_item(CMD_NEXT_IN, 7'd0);
    send_item(CMD_POWER_ON, 7'd127);
    send_item(CMD_POWER_ON, 7'd0);
    send_item(CMD_SET_VOL, 7'd127);
    send_item(CMD_POWER_OFF, 7'd1);
    send_item(CMD_POWER_ON, 7'd64);
    wait_drained();

    // Random commands, mostly volume changes
    for (n = 0; n < 147; n++) begin
      if (n == 60) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      if (n == 110) begin
        send_idle_pct = 6;
        recv_idle_pct <= 6;
      end
      if (n == 140)
        wait_drained();
      pick = $urandom_range(99);
      if (pick < 60)
        cmd = CMD_SET_VOL;
      else if (pick < 78)
        cmd = CMD_NEXT_IN;
      else if (pick < 89)
        cmd = CMD_POWER_ON;
      else
        cmd = CMD_POWER_OFF;
      pick = $urandom_range(9);
      if (pick == 0)
        vol = last_volume;
      else if (pick == 1)
        vol = '0;
      else if (pick == 2)
        vol = 7'd127;
      else if (pick == 3)
        vol = last_volume ^ VOL_W'(1 << $urandom_range(VOL_W - 1));
      else
        vol = VOL_W'($urandom_range(127));
      send_item(cmd, vol);
    end

    // Drain, let the sequencer settle, then check for leftovers
    wait_drained();
    repeat (20) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
